// File: sv/hsvtbb_pkg.sv
// Shared types, constants and tables for the HSV threshold bounding box block.
package hsvtbb_pkg;

    localparam int unsigned COORD_W = 12;
    localparam int unsigned SIZE_W  = 13;

    typedef enum logic [2:0] {
        CFG_HUE_LOW  = 3'd0,
        CFG_SAT_LOW  = 3'd1,
        CFG_VAL_LOW  = 3'd2,
        CFG_HUE_HIGH = 3'd3,
        CFG_SAT_HIGH = 3'd4,
        CFG_VAL_HIGH = 3'd5
    } t_cfg_idx;

    localparam logic [7:0] RST_HUE_LOW  = 8'd0;
    localparam logic [7:0] RST_SAT_LOW  = 8'd100;
    localparam logic [7:0] RST_VAL_LOW  = 8'd100;
    localparam logic [7:0] RST_HUE_HIGH = 8'd10;
    localparam logic [7:0] RST_SAT_HIGH = 8'd255;
    localparam logic [7:0] RST_VAL_HIGH = 8'd255;

    localparam int unsigned HUE_SPAN = 180;

    localparam logic [31:0] SAT_NUM = 32'd255 * 32'd4096;
    localparam logic [31:0] HUE_NUM = 32'd30 * 32'd4096;

    // queue entry between front and back
    typedef struct packed {
        logic match;
        logic eol;
        logic eof;
    } t_cls;

    typedef struct packed {
        logic [7:0] hue_low;
        logic [7:0] sat_low;
        logic [7:0] val_low;
        logic [7:0] hue_high;
        logic [7:0] sat_high;
        logic [7:0] val_high;
    } t_cfg;

    typedef logic [19:0] t_recip_tab [256];

    // round(num/den), 0 for den == 0: largest q with 2*q*den <= 2*num + den
    function automatic logic [19:0] round_recip(input logic [31:0] num,
                                                input logic [31:0] den);
        logic [31:0] q, t;
        q = 32'd0;
        if (den != 32'd0) begin
            for (int b = 20; b >= 0; b--) begin
                t = q | (32'd1 << b);
                if (64'(t) * 64'(den) * 64'd2 <= 64'(num) * 64'd2 + 64'(den)) q = t;
            end
        end
        return q[19:0];
    endfunction

    function automatic t_recip_tab recip_table(input logic [31:0] num);
        t_recip_tab t;
        for (int d = 0; d < 256; d++) t[d] = round_recip(num, 32'(d));
        return t;
    endfunction

    localparam t_recip_tab SAT_RECIP = recip_table(SAT_NUM);
    localparam t_recip_tab HUE_RECIP = recip_table(HUE_NUM);

endpackage

// File: sv/hsv_threshold_bounding_box.sv
// Top level: HSV threshold bounding box over a raster RGB pixel stream.
// Result path: the end-of-frame item passes 3 front stages and the queue, then sets the box reg.
// Throughput: one pixel per cycle (front pipeline, 4-entry queue) unless a held result stalls.
// Reset: synchronous active low; registers return to defaults, counters and box clear.
// No clearing pass; the block accepts pixels the cycle after reset is released.
module hsv_threshold_bounding_box #(
    parameter int unsigned MAX_WIDTH  = 4096,
    parameter int unsigned MAX_HEIGHT = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // pixel_red, pixel_green, pixel_blue
    input  logic        s_axis_tlast,   // end_of_frame
    input  logic        s_axis_tuser,   // end_of_line
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,   // found, box_x, box_y, box_w, box_h, zero pad
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [7:0]  i_cfg_data
);
    import hsvtbb_pkg::*;

    t_cfg               r_cfg;
    t_cls               f_cls, q_cls;
    logic               f_valid, f_ready, q_valid, q_ready;
    logic               found;
    logic [COORD_W-1:0] bx, by;
    logic [SIZE_W-1:0]  bw, bh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.hue_low  <= RST_HUE_LOW;
            r_cfg.sat_low  <= RST_SAT_LOW;
            r_cfg.val_low  <= RST_VAL_LOW;
            r_cfg.hue_high <= RST_HUE_HIGH;
            r_cfg.sat_high <= RST_SAT_HIGH;
            r_cfg.val_high <= RST_VAL_HIGH;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_HUE_LOW:  r_cfg.hue_low  <= i_cfg_data;
                CFG_SAT_LOW:  r_cfg.sat_low  <= i_cfg_data;
                CFG_VAL_LOW:  r_cfg.val_low  <= i_cfg_data;
                CFG_HUE_HIGH: r_cfg.hue_high <= i_cfg_data;
                CFG_SAT_HIGH: r_cfg.sat_high <= i_cfg_data;
                CFG_VAL_HIGH: r_cfg.val_high <= i_cfg_data;
                default: ;
            endcase
        end
    end

    hsvtbb_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_red   (s_axis_tdata[7:0]),
        .i_green (s_axis_tdata[15:8]),
        .i_blue  (s_axis_tdata[23:16]),
        .i_eol   (s_axis_tuser),
        .i_eof   (s_axis_tlast),
        .i_cfg   (r_cfg),
        .o_valid (f_valid),
        .i_ready (f_ready),
        .o_cls   (f_cls)
    );

    hsvtbb_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .o_ready (f_ready),
        .i_data  (f_cls),
        .o_valid (q_valid),
        .i_ready (q_ready),
        .o_data  (q_cls)
    );

    hsvtbb_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .o_ready (q_ready),
        .i_cls   (q_cls),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_found (found),
        .o_x     (bx),
        .o_y     (by),
        .o_w     (bw),
        .o_h     (bh)
    );

    assign m_axis_tdata = {5'd0, bh, bw, by, bx, found};
endmodule

// File: sv/hsvtbb_front.sv
// Front end: pipelined RGB to HSV conversion and threshold classification.
module hsvtbb_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [7:0]         i_red,
    input  logic [7:0]         i_green,
    input  logic [7:0]         i_blue,
    input  logic               i_eol,
    input  logic               i_eof,
    input  hsvtbb_pkg::t_cfg   i_cfg,
    output logic               o_valid,
    input  logic               i_ready,
    output hsvtbb_pkg::t_cls   o_cls
);
    import hsvtbb_pkg::*;

    // stage 1: max/min, sector numerator, reciprocals
    logic               r_v1;
    logic [7:0]         r_mx1;
    logic [7:0]         r_diff1;
    logic signed [11:0] r_hh1;
    logic [19:0]        r_sr1;
    logic [16:0]        r_hr1;
    logic               r_eol1, r_eof1;
    // stage 2: products
    logic               r_v2;
    logic [7:0]         r_mx2;
    logic [27:0]        r_sp2;
    logic signed [28:0] r_hp2;
    logic               r_eol2, r_eof2;
    // stage 3: classified output
    logic               r_v3;
    t_cls               r_cls3;

    logic [7:0]         mx, mn, diff;
    logic signed [11:0] hh;
    logic               adv3, adv2, adv1;
    logic [27:0]        s_sum;
    logic [7:0]         sat;
    logic signed [29:0] h_sum;
    logic signed [17:0] h_raw;
    logic signed [17:0] h_adj;
    logic [7:0]         hue;
    logic               match;

    assign adv3    = !r_v3 || i_ready;
    assign adv2    = !r_v2 || adv3;
    assign adv1    = !r_v1 || adv2;
    assign o_ready = adv1;
    assign o_valid = r_v3;
    assign o_cls   = r_cls3;

    always_comb begin
        mx = i_red;
        mn = i_red;
        if (i_green > mx) mx = i_green;
        if (i_blue > mx) mx = i_blue;
        if (i_green < mn) mn = i_green;
        if (i_blue < mn) mn = i_blue;
        diff = mx - mn;
        priority if (mx == i_red) begin
            hh = $signed({4'd0, i_green}) - $signed({4'd0, i_blue});
        end else if (mx == i_green) begin
            hh = $signed({4'd0, i_blue}) - $signed({4'd0, i_red})
                 + $signed({3'd0, diff, 1'b0});
        end else begin
            hh = $signed({4'd0, i_red}) - $signed({4'd0, i_green})
                 + $signed({2'd0, diff, 2'b0});
        end
    end

    always_comb begin
        s_sum = r_sp2 + 28'd2048;
        sat   = s_sum[19:12];
        h_sum = {r_hp2[28], r_hp2} + 30'sd2048 + 30'sd1048576;
        h_raw = $signed({1'b0, h_sum[28:12]}) - 18'sd256;
        h_adj = h_raw[17] ? h_raw + 18'sd180 : h_raw;
        hue   = h_adj[7:0];
        match = hue >= i_cfg.hue_low && hue <= i_cfg.hue_high &&
                sat >= i_cfg.sat_low && sat <= i_cfg.sat_high &&
                r_mx2 >= i_cfg.val_low && r_mx2 <= i_cfg.val_high;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (adv1) r_v1 <= i_valid;
            if (adv2) r_v2 <= r_v1;
            if (adv3) r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv1) begin
            r_mx1   <= mx;
            r_diff1 <= diff;
            r_hh1   <= hh;
            r_sr1   <= SAT_RECIP[mx];
            r_hr1   <= HUE_RECIP[diff][16:0];
            r_eol1  <= i_eol;
            r_eof1  <= i_eof;
        end
        if (adv2) begin
            r_mx2  <= r_mx1;
            r_sp2  <= {20'd0, r_diff1} * {8'd0, r_sr1};
            r_hp2  <= 29'(r_hh1) * $signed({12'd0, r_hr1});
            r_eol2 <= r_eol1;
            r_eof2 <= r_eof1;
        end
        if (adv3) begin
            r_cls3.match <= match;
            r_cls3.eol   <= r_eol2;
            r_cls3.eof   <= r_eof2;
        end
    end
endmodule

// File: sv/hsvtbb_fifo.sv
// Short queue between classification and box tracking.
module hsvtbb_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  hsvtbb_pkg::t_cls i_data,
    output logic             o_valid,
    input  logic             i_ready,
    output hsvtbb_pkg::t_cls o_data
);
    import hsvtbb_pkg::*;

    t_cls       r_mem [4];
    logic [1:0] r_wp, r_rp;
    logic [2:0] r_cnt;
    logic       wr, rd;

    assign o_ready = r_cnt != 3'd4;
    assign o_valid = r_cnt != 3'd0;
    assign o_data  = r_mem[r_rp];
    assign wr      = i_valid && o_ready;
    assign rd      = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (wr) r_mem[r_wp] <= i_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 2'd0;
            r_rp  <= 2'd0;
            r_cnt <= 3'd0;
        end else begin
            if (wr) r_wp <= r_wp + 2'd1;
            if (rd) r_rp <= r_rp + 2'd1;
            r_cnt <= r_cnt + {2'd0, wr} - {2'd0, rd};
        end
    end
endmodule

// File: sv/hsvtbb_back.sv
// Back end: position counters, bounding box tracking and frame result register.
module hsvtbb_back #(
    parameter int unsigned MAX_WIDTH  = 4096,
    parameter int unsigned MAX_HEIGHT = 4096
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  hsvtbb_pkg::t_cls                   i_cls,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic                               o_found,
    output logic [hsvtbb_pkg::COORD_W-1:0]     o_x,
    output logic [hsvtbb_pkg::COORD_W-1:0]     o_y,
    output logic [hsvtbb_pkg::SIZE_W-1:0]      o_w,
    output logic [hsvtbb_pkg::SIZE_W-1:0]      o_h
);
    import hsvtbb_pkg::*;

    localparam int unsigned WLIM = (MAX_WIDTH - 1 > 4095) ? 4095 : MAX_WIDTH - 1;
    localparam int unsigned HLIM = (MAX_HEIGHT - 1 > 4095) ? 4095 : MAX_HEIGHT - 1;
    localparam logic [COORD_W-1:0] COL_LIM = COORD_W'(WLIM);
    localparam logic [COORD_W-1:0] ROW_LIM = COORD_W'(HLIM);

    logic [COORD_W-1:0] r_col, r_row, r_minc, r_maxc, r_minr, r_maxr;
    logic               r_any;
    logic               r_ov;
    logic               r_found;
    logic [COORD_W-1:0] r_x, r_y;
    logic [SIZE_W-1:0]  r_w, r_h;

    logic [COORD_W-1:0] n_minc, n_maxc, n_minr, n_maxr;
    logic               n_any;
    logic               take;

    assign o_ready = !r_ov || i_ready;
    assign take    = i_valid && o_ready;
    assign o_valid = r_ov;
    assign o_found = r_found;
    assign o_x     = r_x;
    assign o_y     = r_y;
    assign o_w     = r_w;
    assign o_h     = r_h;

    always_comb begin
        n_minc = r_minc;
        n_maxc = r_maxc;
        n_minr = r_minr;
        n_maxr = r_maxr;
        n_any  = r_any;
        if (i_cls.match) begin
            n_any = 1'b1;
            if (!r_any) begin
                n_minc = r_col;
                n_maxc = r_col;
                n_minr = r_row;
                n_maxr = r_row;
            end else begin
                if (r_col < r_minc) n_minc = r_col;
                if (r_col > r_maxc) n_maxc = r_col;
                if (r_row < r_minr) n_minr = r_row;
                if (r_row > r_maxr) n_maxr = r_row;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_any  <= 1'b0;
            r_minc <= '0;
            r_maxc <= '0;
            r_minr <= '0;
            r_maxr <= '0;
            r_ov   <= 1'b0;
        end else begin
            if (r_ov && i_ready) r_ov <= 1'b0;
            if (take) begin
                if (i_cls.eof) begin
                    r_ov   <= 1'b1;
                    r_col  <= '0;
                    r_row  <= '0;
                    r_any  <= 1'b0;
                    r_minc <= '0;
                    r_maxc <= '0;
                    r_minr <= '0;
                    r_maxr <= '0;
                end else begin
                    r_any  <= n_any;
                    r_minc <= n_minc;
                    r_maxc <= n_maxc;
                    r_minr <= n_minr;
                    r_maxr <= n_maxr;
                    if (i_cls.eol) begin
                        r_col <= '0;
                        if (r_row < ROW_LIM) r_row <= r_row + COORD_W'(1);
                    end else if (r_col < COL_LIM) begin
                        r_col <= r_col + COORD_W'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && i_cls.eof) begin
            r_found <= n_any;
            if (n_any) begin
                r_x <= n_minc;
                r_y <= n_minr;
                r_w <= {1'b0, n_maxc} - {1'b0, n_minc} + SIZE_W'(1);
                r_h <= {1'b0, n_maxr} - {1'b0, n_minr} + SIZE_W'(1);
            end else begin
                r_x <= '0;
                r_y <= '0;
                r_w <= '0;
                r_h <= '0;
            end
        end
    end
endmodule
